FILE: rtl/max_two_disjoint_window_sums_top_defines.svh
// Assertion macros for the two-window best-sum block.
// Used by the core module to check its own control logic; no other dependencies.
`ifndef MAX_TWO_DISJOINT_WINDOW_SUMS_TOP_DEFINES_SVH
`define MAX_TWO_DISJOINT_WINDOW_SUMS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset
`define MTDWS_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);
// Check that a condition leads to another in the next cycle
`define MTDWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MTDWS_ASSERT(label, expr, msg)
`define MTDWS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/mtdws_pkg.sv
// Package for the two-window best-sum block: widths, register indexes, types, helpers.
// No dependencies; used by every other RTL file except the assertion macro header.
`default_nettype none

package mtdws_pkg;

    localparam int MAX_WIN    = 64;
    localparam int HIST_DEPTH = 2 * MAX_WIN;
    localparam int PTR_W      = $clog2(HIST_DEPTH);
    localparam int VAL_W      = 16;
    localparam int LEN_W      = 7;
    localparam int EFF_W      = $clog2(MAX_WIN + 1);
    localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
    localparam int SUM_W      = $clog2(MAX_WIN * (2 ** VAL_W - 1) + 1);
    localparam int TOT_W      = 23;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // Register indexes, matched against address bit 2 (byte address is index times four)
    localparam logic REG_K_LEN = 1'b0;
    localparam logic REG_L_LEN = 1'b1;

    localparam logic [LEN_W-1:0] K_LEN_RST = LEN_W'(3);
    localparam logic [LEN_W-1:0] L_LEN_RST = LEN_W'(2);

    // Effective window lengths and their sum
    typedef struct packed {
        logic [EFF_W-1:0] k_eff;
        logic [EFF_W-1:0] l_eff;
        logic [CNT_W-1:0] both;
    } t_cfg;

    // History write request
    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
        logic [VAL_W-1:0] data;
    } t_hist_wr;

    // History read addresses, one per lag
    typedef struct packed {
        logic [PTR_W-1:0] a_k;
        logic [PTR_W-1:0] a_l;
        logic [PTR_W-1:0] a_b;
    } t_rd_addr;

    // History read data, one per lag
    typedef struct packed {
        logic [VAL_W-1:0] d_k;
        logic [VAL_W-1:0] d_l;
        logic [VAL_W-1:0] d_b;
    } t_rd_data;

    // Clamp a raw length to 1..MAX_WIN
    function automatic logic [EFF_W-1:0] eff_len(input logic [LEN_W-1:0] r);
        logic [EFF_W-1:0] e;
        if (r == '0) begin
            e = EFF_W'(1);
        end else if (int'(r) > MAX_WIN) begin
            e = EFF_W'(MAX_WIN);
        end else begin
            e = EFF_W'(r);
        end
        return e;
    endfunction

    // Ring position lag entries behind wp, 1 <= lag <= HIST_DEPTH
    function automatic logic [PTR_W-1:0] ring_back(input logic [PTR_W-1:0] wp,
                                                   input logic [CNT_W-1:0] lag);
        logic [CNT_W:0] t;
        t = (CNT_W+1)'(wp) + (CNT_W+1)'(HIST_DEPTH) - (CNT_W+1)'(lag);
        if (t >= (CNT_W+1)'(HIST_DEPTH)) begin
            t = t - (CNT_W+1)'(HIST_DEPTH);
        end
        return PTR_W'(t);
    endfunction

    // Advance a ring pointer by one
    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] wp);
        logic [PTR_W-1:0] n;
        if (wp == PTR_W'(HIST_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = wp + PTR_W'(1);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mtdws_ifs.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on mtdws_pkg for field widths.
`default_nettype none

interface mtdws_in_if;
    logic                         valid;
    logic                         ready;
    logic [mtdws_pkg::VAL_W-1:0]  value;
    logic                         last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface mtdws_out_if;
    logic                         valid;
    logic                         ready;
    logic [mtdws_pkg::TOT_W-1:0]  best_sum;
    logic                         status;

    modport source (output valid, output best_sum, output status, input ready);
    modport sink   (input valid, input best_sum, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/mtdws_cfg.sv
// APB-style register file for the window lengths, with length clamping.
// Depends on mtdws_pkg.
`default_nettype none

module mtdws_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_psel,
    input  wire logic                           i_penable,
    input  wire logic                           i_pwrite,
    input  wire logic [mtdws_pkg::ADDR_W-1:0]   i_paddr,
    input  wire logic [mtdws_pkg::DATA_W-1:0]   i_pwdata,
    output logic      [mtdws_pkg::DATA_W-1:0]   o_prdata,
    output mtdws_pkg::t_cfg                     o_cfg,
    output logic                                o_cfg_wr
);

    logic [mtdws_pkg::LEN_W-1:0] r_k_len;
    logic [mtdws_pkg::LEN_W-1:0] r_l_len;
    logic                        reg_sel;
    logic                        wr_en;

    // Registers are word aligned: bit 2 of the address selects one
    assign reg_sel  = i_paddr[2];
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign o_cfg_wr = wr_en;

    // Write the selected length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_len <= mtdws_pkg::K_LEN_RST;
            r_l_len <= mtdws_pkg::L_LEN_RST;
        end else if (wr_en) begin
            case (reg_sel)
                mtdws_pkg::REG_K_LEN: r_k_len <= i_pwdata[mtdws_pkg::LEN_W-1:0];
                mtdws_pkg::REG_L_LEN: r_l_len <= i_pwdata[mtdws_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the raw register value
    always_comb begin
        case (reg_sel)
            mtdws_pkg::REG_K_LEN: o_prdata = mtdws_pkg::DATA_W'(r_k_len);
            mtdws_pkg::REG_L_LEN: o_prdata = mtdws_pkg::DATA_W'(r_l_len);
            default:              o_prdata = '0;
        endcase
    end

    // Clamp lengths and form their sum
    always_comb begin
        o_cfg.k_eff = mtdws_pkg::eff_len(r_k_len);
        o_cfg.l_eff = mtdws_pkg::eff_len(r_l_len);
        o_cfg.both  = mtdws_pkg::CNT_W'(o_cfg.k_eff) + mtdws_pkg::CNT_W'(o_cfg.l_eff);
    end

endmodule

`default_nettype wire

FILE: rtl/mtdws_hist.sv
// Ring of recent values, kept in three identical banks so each lag has its own read port.
// Depends on mtdws_pkg. Read data is registered, with a bypass for a same-edge write.
`default_nettype none

module mtdws_hist (
    input  wire logic                 i_clk,
    input  wire mtdws_pkg::t_hist_wr  i_wr,
    input  wire mtdws_pkg::t_rd_addr  i_rd_addr,
    output mtdws_pkg::t_rd_data       o_rd_data
);

    logic [mtdws_pkg::VAL_W-1:0] r_bank_k [mtdws_pkg::HIST_DEPTH];
    logic [mtdws_pkg::VAL_W-1:0] r_bank_l [mtdws_pkg::HIST_DEPTH];
    logic [mtdws_pkg::VAL_W-1:0] r_bank_b [mtdws_pkg::HIST_DEPTH];
    logic [mtdws_pkg::VAL_W-1:0] r_rd_k;
    logic [mtdws_pkg::VAL_W-1:0] r_rd_l;
    logic [mtdws_pkg::VAL_W-1:0] r_rd_b;
    logic [mtdws_pkg::VAL_W-1:0] r_wr_data;
    logic                        r_byp_k;
    logic                        r_byp_l;
    logic                        r_byp_b;

    // Bank for the K lag
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_bank_k[i_wr.addr] <= i_wr.data;
        end
        r_rd_k <= r_bank_k[i_rd_addr.a_k];
    end

    // Bank for the L lag
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_bank_l[i_wr.addr] <= i_wr.data;
        end
        r_rd_l <= r_bank_l[i_rd_addr.a_l];
    end

    // Bank for the K+L lag
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_bank_b[i_wr.addr] <= i_wr.data;
        end
        r_rd_b <= r_bank_b[i_rd_addr.a_b];
    end

    // Note reads that hit the entry written at the same edge
    always_ff @(posedge i_clk) begin
        r_wr_data <= i_wr.data;
        r_byp_k   <= i_wr.en && (i_rd_addr.a_k == i_wr.addr);
        r_byp_l   <= i_wr.en && (i_rd_addr.a_l == i_wr.addr);
        r_byp_b   <= i_wr.en && (i_rd_addr.a_b == i_wr.addr);
    end

    assign o_rd_data.d_k = r_byp_k ? r_wr_data : r_rd_k;
    assign o_rd_data.d_l = r_byp_l ? r_wr_data : r_rd_l;
    assign o_rd_data.d_b = r_byp_b ? r_wr_data : r_rd_b;

endmodule

`default_nettype wire

FILE: rtl/mtdws_core.sv
// Input register, running window sums and bests, and result register.
// Depends on mtdws_pkg, the channel interfaces and the assertion macro header.
`default_nettype none
`include "max_two_disjoint_window_sums_top_defines.svh"

module mtdws_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    mtdws_in_if.sink                  i_in,
    mtdws_out_if.source               o_out,
    input  wire mtdws_pkg::t_cfg      i_cfg,
    input  wire logic                 i_cfg_wr,
    output mtdws_pkg::t_hist_wr       o_hist_wr,
    output mtdws_pkg::t_rd_addr       o_rd_addr,
    input  wire mtdws_pkg::t_rd_data  i_rd_data
);

    // Input register
    logic                         r_in_valid;
    logic [mtdws_pkg::VAL_W-1:0]  r_value;
    logic                         r_last;

    // Sequence state
    logic [mtdws_pkg::PTR_W-1:0]  r_wp,  n_wp;
    logic [mtdws_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [mtdws_pkg::SUM_W-1:0]  r_sk,  n_sk;
    logic [mtdws_pkg::SUM_W-1:0]  r_sl,  n_sl;
    logic [mtdws_pkg::SUM_W-1:0]  r_skl, n_skl;
    logic [mtdws_pkg::SUM_W-1:0]  r_sll, n_sll;
    logic [mtdws_pkg::SUM_W-1:0]  r_bk,  n_bk;
    logic [mtdws_pkg::SUM_W-1:0]  r_bl,  n_bl;
    logic [mtdws_pkg::TOT_W-1:0]  r_bt,  n_bt;

    // Result register
    logic                         r_out_valid;
    logic [mtdws_pkg::TOT_W-1:0]  r_best_sum, n_best_sum;
    logic                         r_status,   n_status;

    logic                         proc;
    logic                         seq_clear;
    logic                         ge_k, ge_l, ge_b;
    logic [mtdws_pkg::SUM_W-1:0]  sub_k, sub_l, sub_b;
    logic [mtdws_pkg::SUM_W-1:0]  v_ext;
    logic [mtdws_pkg::CNT_W-1:0]  cnt_upd;
    logic                         full;
    logic [mtdws_pkg::TOT_W-1:0]  c1, c2, bt_a;

    // An item with no result never waits on the output side
    assign proc       = r_in_valid && (!r_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || proc;
    assign seq_clear  = i_cfg_wr || (proc && r_last);

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_value <= i_in.value;
            r_last  <= i_in.last;
        end
    end

    // Window updates for the item in the input register
    always_comb begin
        ge_k    = r_cnt >= mtdws_pkg::CNT_W'(i_cfg.k_eff);
        ge_l    = r_cnt >= mtdws_pkg::CNT_W'(i_cfg.l_eff);
        ge_b    = r_cnt >= i_cfg.both;
        sub_k   = ge_k ? mtdws_pkg::SUM_W'(i_rd_data.d_k) : '0;
        sub_l   = ge_l ? mtdws_pkg::SUM_W'(i_rd_data.d_l) : '0;
        sub_b   = ge_b ? mtdws_pkg::SUM_W'(i_rd_data.d_b) : '0;
        v_ext   = mtdws_pkg::SUM_W'(r_value);

        n_sk    = r_sk + v_ext - sub_k;
        n_sl    = r_sl + v_ext - sub_l;
        n_skl   = r_skl + sub_l - sub_b;
        n_sll   = r_sll + sub_k - sub_b;

        cnt_upd = (r_cnt < i_cfg.both) ? r_cnt + mtdws_pkg::CNT_W'(1) : r_cnt;
        full    = cnt_upd >= i_cfg.both;

        // Running bests only once both windows fit
        n_bk    = (full && (n_skl > r_bk)) ? n_skl : r_bk;
        n_bl    = (full && (n_sll > r_bl)) ? n_sll : r_bl;
        c1      = mtdws_pkg::TOT_W'(n_bk) + mtdws_pkg::TOT_W'(n_sl);
        c2      = mtdws_pkg::TOT_W'(n_bl) + mtdws_pkg::TOT_W'(n_sk);
        bt_a    = (c1 > r_bt) ? c1 : r_bt;
        n_bt    = full ? ((c2 > bt_a) ? c2 : bt_a) : r_bt;

        n_status   = !full;
        n_best_sum = full ? n_bt : '0;
        n_cnt      = cnt_upd;

        // Next write pointer also steers the history pre-read
        if (seq_clear) begin
            n_wp = '0;
        end else if (proc) begin
            n_wp = mtdws_pkg::ring_inc(r_wp);
        end else begin
            n_wp = r_wp;
        end
    end

    // Pre-read the three lagged entries for the next item
    assign o_rd_addr.a_k = mtdws_pkg::ring_back(n_wp, mtdws_pkg::CNT_W'(i_cfg.k_eff));
    assign o_rd_addr.a_l = mtdws_pkg::ring_back(n_wp, mtdws_pkg::CNT_W'(i_cfg.l_eff));
    assign o_rd_addr.a_b = mtdws_pkg::ring_back(n_wp, i_cfg.both);

    assign o_hist_wr.en   = proc;
    assign o_hist_wr.addr = r_wp;
    assign o_hist_wr.data = r_value;

    // Advance or clear the sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || seq_clear) begin
            r_wp  <= '0;
            r_cnt <= '0;
            r_sk  <= '0;
            r_sl  <= '0;
            r_skl <= '0;
            r_sll <= '0;
            r_bk  <= '0;
            r_bl  <= '0;
            r_bt  <= '0;
        end else if (proc) begin
            r_wp  <= n_wp;
            r_cnt <= n_cnt;
            r_sk  <= n_sk;
            r_sl  <= n_sl;
            r_skl <= n_skl;
            r_sll <= n_sll;
            r_bk  <= n_bk;
            r_bl  <= n_bl;
            r_bt  <= n_bt;
        end
    end

    // Load the result on the last item, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_last) begin
            r_best_sum <= n_best_sum;
            r_status   <= n_status;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.best_sum = r_best_sum;
    assign o_out.status   = r_status;

    // Self checks
    `MTDWS_ASSERT(a_cnt_sat, r_cnt <= i_cfg.both, "item count above K+L")
    `MTDWS_ASSERT(a_wp_track, (r_cnt >= i_cfg.both) || (r_wp == r_cnt[mtdws_pkg::PTR_W-1:0]), "ptr skew")
    `MTDWS_ASSERT_NEXT(a_end_clear, proc && r_last, ~|{r_cnt, r_wp, r_bt}, "not cleared")
    `MTDWS_ASSERT(a_short_zero, !(r_out_valid && r_status) || ~|r_best_sum, "short sum not zero")

endmodule

`default_nettype wire

FILE: rtl/max_two_disjoint_window_sums_top.sv
// Best total of two disjoint windows: one item per cycle unless a last item waits on a held result.
// Throughput 1 item per clock save that wait; the whole update runs between input and result registers.
// Result registered as its last item leaves the input register; a last item waits while one is held.
// Synchronous active-low reset: lengths to 3 and 2, sequence state cleared, no memory sweep.
// Top level: ties the register port, the history ring and the core together.
// Depends on mtdws_pkg, the channel interfaces, mtdws_cfg, mtdws_hist and mtdws_core.
`default_nettype none

module max_two_disjoint_window_sums_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    mtdws_in_if.sink                            i_in,
    mtdws_out_if.source                         o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mtdws_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mtdws_pkg::DATA_W-1:0]   pwdata,
    output logic      [mtdws_pkg::DATA_W-1:0]   prdata,
    output logic                                pready
);

    mtdws_pkg::t_cfg      cfg;
    logic                 cfg_wr;
    mtdws_pkg::t_hist_wr  hist_wr;
    mtdws_pkg::t_rd_addr  rd_addr;
    mtdws_pkg::t_rd_data  rd_data;

    // Zero-wait register access
    assign pready = 1'b1;

    mtdws_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg),
        .o_cfg_wr  (cfg_wr)
    );

    mtdws_hist u_hist (
        .i_clk     (i_clk),
        .i_wr      (hist_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mtdws_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .i_cfg     (cfg),
        .i_cfg_wr  (cfg_wr),
        .o_hist_wr (hist_wr),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

endmodule

`default_nettype wire
